// ===== hw/rtl/tlvsp_pkg.sv =====
// Package for the TLV security policy parser.
// Holds the header and record geometry, status codes and register indexes.
// No dependencies.
package tlvsp_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
  localparam int POLICY_LEN   = 8;
  localparam int PIDX_W       = $clog2(POLICY_LEN) + 1;
  localparam int MAGIC_BYTES  = 4;
  localparam int VERSION_POS  = 4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_VER   = 3'd1;
  localparam logic [2:0] ST_OOB       = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_TRAILING  = 3'd4;

  localparam logic [1:0] REG_MAGIC    = 2'd0;
  localparam logic [1:0] REG_VERSION  = 2'd1;
  localparam logic [1:0] REG_TAG      = 2'd2;

endpackage

// ===== hw/rtl/tlv_security_policy_parser.sv =====
// TLV security policy parser: header check, record walk and policy capture.
// Depends on tlvsp_pkg.
//
// Usage: metadata bytes arrive on the data channel (data_valid/data_ready),
// one request per byte, with last_byte marking the final byte of a blob.
// Each byte updates a small parse state, so one byte is taken every cycle
// while data_ready is high. The byte that carries last_byte produces one
// request on the result channel (result_valid/result_ready) the cycle after
// it is accepted; all other bytes produce nothing. The parse state returns
// to its start values once the last byte is accepted, so the next blob can
// follow in the very next cycle. The result register frees as soon as it is
// taken: while a result waits and result_ready is low, data_ready drops,
// otherwise bytes keep flowing. Configuration writes on cfg_write/cfg_index/
// cfg_data take effect at the next edge and are meant for idle periods only.
// Synchronous reset clears the parse state, empties the result register and
// loads the register defaults: magic 0, version 1, policy tag 1.
module tlv_security_policy_parser
  import tlvsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  status,
  output logic        policy_present,
  output logic [7:0]  policy_version,
  output logic [7:0]  policy_mode,
  output logic [15:0] policy_stack_limit,
  output logic [31:0] policy_jump_limit
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_RECHDR  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_SKIP    = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  logic [31:0] magic_word;
  logic [7:0]  expected_version;
  logic [7:0]  policy_tag;

  logic [2:0]           phase, phase_next;
  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic                 magic_matched, magic_matched_next;
  logic                 version_bad, version_bad_next;
  logic [1:0]           rec_hdr_count, rec_hdr_count_next;
  logic                 record_is_policy, record_is_policy_next;
  logic [7:0]           length_low_hold, length_low_hold_next;
  logic [15:0]          record_length, record_length_next;
  logic [15:0]          payload_remaining, payload_remaining_next;
  logic [PIDX_W-1:0]    payload_index, payload_index_next;
  logic [2:0]           error_latched, error_latched_next;
  logic                 found_flag, found_flag_next;
  logic [63:0]          stored_policy, stored_policy_next;
  logic [63:0]          candidate_policy, candidate_policy_next;

  logic        do_finish;
  logic        accept;
  logic [2:0]  res_status;
  logic        res_present;

  assign data_ready = !result_valid || result_ready;
  assign accept     = data_valid && data_ready;

  always_comb begin
    phase_next             = phase;
    header_count_next      = header_count;
    magic_matched_next     = magic_matched;
    version_bad_next       = version_bad;
    rec_hdr_count_next     = rec_hdr_count;
    record_is_policy_next  = record_is_policy;
    length_low_hold_next   = length_low_hold;
    record_length_next     = record_length;
    payload_remaining_next = payload_remaining;
    payload_index_next     = payload_index;
    error_latched_next     = error_latched;
    found_flag_next        = found_flag;
    stored_policy_next     = stored_policy;
    candidate_policy_next  = candidate_policy;
    do_finish              = 1'b0;

    case (phase)
      PH_HEADER: begin
        if (header_count < HDR_CNT_W'(MAGIC_BYTES) &&
            data_byte != magic_word[{header_count[1:0], 3'b000} +: 8]) begin
          magic_matched_next = 1'b0;
        end
        if (header_count == HDR_CNT_W'(VERSION_POS) && data_byte != expected_version) begin
          version_bad_next = 1'b1;
        end
        if (header_count >= HDR_CNT_W'(HEADER_BYTES - 1)) begin
          if (!magic_matched_next) begin
            phase_next = PH_SKIP;
          end else if (version_bad_next) begin
            error_latched_next = ST_BAD_VER;
            phase_next         = PH_DONE;
          end else begin
            phase_next         = PH_RECHDR;
            rec_hdr_count_next = 2'd0;
          end
        end else begin
          header_count_next = header_count + HDR_CNT_W'(1);
        end
      end
      PH_RECHDR: begin
        case (rec_hdr_count)
          2'd0: begin
            record_is_policy_next = (data_byte == policy_tag);
            candidate_policy_next = '0;
            rec_hdr_count_next    = 2'd1;
          end
          2'd1: begin
            length_low_hold_next = data_byte;
            rec_hdr_count_next   = 2'd2;
          end
          default: begin
            record_length_next     = {data_byte, length_low_hold};
            payload_remaining_next = {data_byte, length_low_hold};
            payload_index_next     = '0;
            rec_hdr_count_next     = 2'd0;
            if ({data_byte, length_low_hold} == 16'd0) begin
              do_finish = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        endcase
      end
      PH_PAYLOAD: begin
        if (record_is_policy && payload_index < PIDX_W'(POLICY_LEN)) begin
          for (int i = 0; i < POLICY_LEN; i++) begin
            if (payload_index[PIDX_W-2:0] == (PIDX_W-1)'(i)) begin
              candidate_policy_next[8*i +: 8] = candidate_policy[8*i +: 8] | data_byte;
            end
          end
        end
        if (payload_index < PIDX_W'(POLICY_LEN)) begin
          payload_index_next = payload_index + PIDX_W'(1);
        end
        payload_remaining_next = payload_remaining - 16'd1;
        if (payload_remaining == 16'd1) begin
          do_finish = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_finish) begin
      phase_next = PH_RECHDR;
      if (record_is_policy_next) begin
        if (record_length_next != 16'(POLICY_LEN)) begin
          error_latched_next = ST_BAD_LEN;
          phase_next         = PH_DONE;
        end else begin
          stored_policy_next = candidate_policy_next;
          found_flag_next    = 1'b1;
        end
      end
    end

    case (phase_next)
      PH_DONE:    res_status = error_latched_next;
      PH_PAYLOAD: res_status = ST_OOB;
      PH_RECHDR:  res_status = (rec_hdr_count_next != 2'd0) ? ST_TRAILING : ST_OK;
      default:    res_status = ST_OK;
    endcase
    res_present = (phase_next == PH_RECHDR) && (res_status == ST_OK) && found_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word       <= '0;
      expected_version <= 8'd1;
      policy_tag       <= 8'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAGIC:   magic_word       <= cfg_data;
        REG_VERSION: expected_version <= cfg_data[7:0];
        REG_TAG:     policy_tag       <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase             <= PH_HEADER;
      header_count      <= '0;
      magic_matched     <= 1'b1;
      version_bad       <= 1'b0;
      rec_hdr_count     <= 2'd0;
      record_is_policy  <= 1'b0;
      length_low_hold   <= '0;
      record_length     <= '0;
      payload_remaining <= '0;
      payload_index     <= '0;
      error_latched     <= ST_OK;
      found_flag        <= 1'b0;
      stored_policy     <= '0;
      candidate_policy  <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      header_count      <= header_count_next;
      magic_matched     <= magic_matched_next;
      version_bad       <= version_bad_next;
      rec_hdr_count     <= rec_hdr_count_next;
      record_is_policy  <= record_is_policy_next;
      length_low_hold   <= length_low_hold_next;
      record_length     <= record_length_next;
      payload_remaining <= payload_remaining_next;
      payload_index     <= payload_index_next;
      error_latched     <= error_latched_next;
      found_flag        <= found_flag_next;
      stored_policy     <= stored_policy_next;
      candidate_policy  <= candidate_policy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      status             <= res_status;
      policy_present     <= res_present;
      policy_version     <= res_present ? stored_policy_next[7:0]   : 8'd0;
      policy_mode        <= res_present ? stored_policy_next[15:8]  : 8'd0;
      policy_stack_limit <= res_present ? stored_policy_next[31:16] : 16'd0;
      policy_jump_limit  <= res_present ? stored_policy_next[63:32] : 32'd0;
    end
  end

  a_present_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && policy_present |-> status == ST_OK)
    else $error("policy reported with a nonzero status");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !policy_present |->
      policy_version == 8'd0 && policy_mode == 8'd0 &&
      policy_stack_limit == 16'd0 && policy_jump_limit == 32'd0)
    else $error("policy fields not cleared when no policy is present");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status <= ST_TRAILING)
    else $error("status code out of range");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !data_ready)
    else $error("byte taken while an untaken result is held");

  a_blob_restart: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> phase == PH_HEADER && header_count == '0 && !found_flag)
    else $error("parse state not restarted after the last byte");

endmodule
